// File: rtl/tlvd_pkg.sv
// shared types and constants for the tlv frame deframer
// no dependencies; compiled first

package tlvd_pkg;

    localparam int unsigned HDR_BYTES = 6;
    localparam int unsigned CNT_W     = 3;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 32;

    localparam logic [CNT_W-1:0] HDR_TYPE_POS  = CNT_W'(0);
    localparam logic [CNT_W-1:0] HDR_FLAGS_POS = CNT_W'(1);
    localparam logic [CNT_W-1:0] HDR_LAST_POS  = CNT_W'(HDR_BYTES - 1);

    typedef enum logic [1:0] {
        KIND_HEADER   = 2'd0,
        KIND_PAYLOAD  = 2'd1,
        KIND_BAD_TYPE = 2'd2,
        KIND_TOO_LONG = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TYPE_A      = 3'd0,
        REG_TYPE_B      = 3'd1,
        REG_TYPE_C      = 3'd2,
        REG_TYPE_D      = 3'd3,
        REG_TYPE_E      = 3'd4,
        REG_MAX_PAYLOAD = 3'd5
    } cfg_idx_t;

    localparam logic [7:0]  RST_TYPE_A      = 8'd1;
    localparam logic [7:0]  RST_TYPE_B      = 8'd2;
    localparam logic [7:0]  RST_TYPE_C      = 8'd3;
    localparam logic [7:0]  RST_TYPE_D      = 8'd4;
    localparam logic [7:0]  RST_TYPE_E      = 8'd5;
    localparam logic [31:0] RST_MAX_PAYLOAD = 32'd1048576;

endpackage

// File: rtl/tlvd_byte_if.sv
// byte stream channel into the deframer
// no dependencies

interface tlvd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// File: rtl/tlvd_result_if.sv
// result channel out of the deframer
// depends on tlvd_pkg for the kind type

interface tlvd_result_if;
    logic                valid;
    logic                ready;
    tlvd_pkg::kind_t     kind;
    logic [7:0]          frame_type;
    logic [7:0]          frame_flags;
    logic [31:0]         payload_length;
    logic [7:0]          data_byte;
    logic                last;

    modport source (output valid, output kind, output frame_type, output frame_flags,
                    output payload_length, output data_byte, output last, input ready);
    modport sink   (input valid, input kind, input frame_type, input frame_flags,
                    input payload_length, input data_byte, input last, output ready);
endinterface

// File: rtl/tlvd_cfg_if.sv
// register write channel of the deframer
// depends on tlvd_pkg for index and data widths

interface tlvd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [tlvd_pkg::CFG_IDX_W-1:0]     index;
    logic [tlvd_pkg::CFG_DAT_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/tlv_frame_deframer.sv
// Splits a byte stream into type-length-value frames: a 6-byte header (type, flags,
// 32-bit big-endian length) followed by the payload. Each accepted byte is decoded in
// the cycle it arrives and its result, if any, lands in a single output register, so
// the block takes one byte per clock as long as the result side keeps up; the input
// is stalled only while that register holds a result not yet taken. A header gives
// one header result (last set when the length is zero), each payload byte gives one
// result, the final one marked last. A type matching none of the five configured codes,
// or a length above max_payload, gives one error result and silences the block until
// reset. Register writes are always taken, one per clock, but should be made while idle.
// depends on tlvd_pkg, tlvd_byte_if, tlvd_result_if, tlvd_cfg_if

module tlv_frame_deframer
(
    input  logic                 clk,
    input  logic                 rst_n,
    tlvd_byte_if.sink            stream,
    tlvd_result_if.source        result,
    tlvd_cfg_if.sink             cfg
);
    import tlvd_pkg::*;

    // configuration registers
    logic [7:0]  type_a_reg, type_b_reg, type_c_reg, type_d_reg, type_e_reg;
    logic [31:0] max_payload_reg;

    // frame state
    logic [CNT_W-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [7:0]       held_type_reg, held_type_next;
    logic [7:0]       held_flags_reg, held_flags_next;
    logic [31:0]      held_len_reg, held_len_next;
    logic [31:0]      bytes_left_reg, bytes_left_next;
    logic             err_reg, err_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    kind_t            kind_reg, kind_next;
    logic [7:0]       otype_reg, otype_next;
    logic [7:0]       oflags_reg, oflags_next;
    logic [31:0]      olen_reg, olen_next;
    logic [7:0]       odata_reg, odata_next;
    logic             olast_reg, olast_next;

    logic in_take;
    logic out_take;
    logic emit;
    logic type_ok;

    assign cfg.ready    = 1'b1;
    assign out_take     = out_valid_reg & result.ready;
    assign stream.ready = ~out_valid_reg | result.ready;
    assign in_take      = stream.valid & stream.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_a_reg      <= RST_TYPE_A;
            type_b_reg      <= RST_TYPE_B;
            type_c_reg      <= RST_TYPE_C;
            type_d_reg      <= RST_TYPE_D;
            type_e_reg      <= RST_TYPE_E;
            max_payload_reg <= RST_MAX_PAYLOAD;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_TYPE_A:      type_a_reg      <= cfg.data[7:0];
                REG_TYPE_B:      type_b_reg      <= cfg.data[7:0];
                REG_TYPE_C:      type_c_reg      <= cfg.data[7:0];
                REG_TYPE_D:      type_d_reg      <= cfg.data[7:0];
                REG_TYPE_E:      type_e_reg      <= cfg.data[7:0];
                REG_MAX_PAYLOAD: max_payload_reg <= cfg.data;
                default:         ;
            endcase
        end
    end

    assign type_ok = (held_type_reg == type_a_reg) || (held_type_reg == type_b_reg) ||
                     (held_type_reg == type_c_reg) || (held_type_reg == type_d_reg) ||
                     (held_type_reg == type_e_reg);

    always_comb
    begin
        hdr_cnt_next    = hdr_cnt_reg;
        held_type_next  = held_type_reg;
        held_flags_next = held_flags_reg;
        held_len_next   = held_len_reg;
        bytes_left_next = bytes_left_reg;
        err_next        = err_reg;
        emit            = 1'b0;
        kind_next       = KIND_HEADER;
        odata_next      = 8'd0;
        olast_next      = 1'b0;

        if (in_take && !err_reg)
        begin
            if (bytes_left_reg != 32'd0)
            begin
                bytes_left_next = bytes_left_reg - 32'd1;
                emit            = 1'b1;
                kind_next       = KIND_PAYLOAD;
                odata_next      = stream.in_byte;
                olast_next      = (bytes_left_reg == 32'd1);
            end
            else
            begin
                if (hdr_cnt_reg == HDR_TYPE_POS)
                begin
                    held_type_next = stream.in_byte;
                end
                else if (hdr_cnt_reg == HDR_FLAGS_POS)
                begin
                    held_flags_next = stream.in_byte;
                end
                else
                begin
                    held_len_next = {held_len_reg[23:0], stream.in_byte};
                end

                if (hdr_cnt_reg == HDR_LAST_POS)
                begin
                    hdr_cnt_next = HDR_TYPE_POS;
                    emit         = 1'b1;
                    // type byte was captured earlier, so type_ok is already settled
                    if (!type_ok)
                    begin
                        err_next  = 1'b1;
                        kind_next = KIND_BAD_TYPE;
                    end
                    else if (held_len_next > max_payload_reg)
                    begin
                        err_next  = 1'b1;
                        kind_next = KIND_TOO_LONG;
                    end
                    else
                    begin
                        bytes_left_next = held_len_next;
                        kind_next       = KIND_HEADER;
                        olast_next      = (held_len_next == 32'd0);
                    end
                end
                else
                begin
                    hdr_cnt_next = hdr_cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg & ~out_take;
        otype_next     = otype_reg;
        oflags_next    = oflags_reg;
        olen_next      = olen_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            otype_next     = held_type_next;
            oflags_next    = held_flags_next;
            olen_next      = held_len_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_cnt_reg    <= HDR_TYPE_POS;
            held_type_reg  <= 8'd0;
            held_flags_reg <= 8'd0;
            held_len_reg   <= 32'd0;
            bytes_left_reg <= 32'd0;
            err_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hdr_cnt_reg    <= hdr_cnt_next;
            held_type_reg  <= held_type_next;
            held_flags_reg <= held_flags_next;
            held_len_reg   <= held_len_next;
            bytes_left_reg <= bytes_left_next;
            err_reg        <= err_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // result payload, loaded only when a new result is produced
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg   <= kind_next;
            odata_reg  <= odata_next;
            olast_reg  <= olast_next;
        end
        otype_reg  <= otype_next;
        oflags_reg <= oflags_next;
        olen_reg   <= olen_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.kind           = kind_reg;
    assign result.frame_type     = otype_reg;
    assign result.frame_flags    = oflags_reg;
    assign result.payload_length = olen_reg;
    assign result.data_byte      = odata_reg;
    assign result.last           = olast_reg;

endmodule
